>>> src/llnt_pkg.sv
package llnt_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1023;
  localparam int DEPTH     = MAX_NODES + 1;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ACT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_UNLINK     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY      = 2'd3;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic phase1;
    logic phase2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic clr_done;
  } status_t;

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = (n != '0) && (32'(n) <= MAX_NODES);
  endfunction

endpackage

>>> src/llnt_ctrl.sv
module llnt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output llnt_pkg::cmd_t    cmd_o,
  input  llnt_pkg::status_t status_i
);
  import llnt_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WR1   = 2'd2;
  localparam logic [1:0] ST_WR2   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_WR1;
      end
      ST_WR1: begin
        if (status_i.is_query) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.phase1 = 1'b1;
          state_d      = ST_WR2;
        end
      end
      ST_WR2: begin
        cmd_o.phase2 = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/llnt_dp.sv
module llnt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [llnt_pkg::ACT_W-1:0]    action_i,
  input  logic [llnt_pkg::NODE_W-1:0]   node_a_i,
  input  logic [llnt_pkg::NODE_W-1:0]   node_b_i,
  output logic [llnt_pkg::NODE_W-1:0]   prev_node_o,
  output logic [llnt_pkg::NODE_W-1:0]   next_node_o,
  input  llnt_pkg::cmd_t                cmd_i,
  output llnt_pkg::status_t             status_o
);
  import llnt_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [NODE_W-1:0] prev_mem [DEPTH];
  logic [NODE_W-1:0] next_mem [DEPTH];

  logic [ACT_W-1:0]  act_q;
  logic [NODE_W-1:0] a_q, b_q;
  logic [NODE_W-1:0] p_q, n_q;
  logic [NODE_W-1:0] prev_out_q, next_out_q;
  logic [ADDR_W-1:0] clr_q;

  logic              a_ok, b_ok, p_ok, n_ok, ins_ok;
  logic              prev_we, next_we;
  logic [NODE_W-1:0] prev_wa, next_wa;
  logic [NODE_W-1:0] prev_wd, next_wd;

  assign a_ok   = node_ok(a_q);
  assign b_ok   = node_ok(b_q);
  assign p_ok   = node_ok(p_q);
  assign n_ok   = node_ok(n_q);
  assign ins_ok = a_ok && b_ok && (b_q != a_q);

  always_comb begin
    prev_we = 1'b0;
    next_we = 1'b0;
    prev_wa = a_q;
    next_wa = a_q;
    prev_wd = '0;
    next_wd = '0;
    if (cmd_i.clr_en) begin
      prev_we = 1'b1;
      next_we = 1'b1;
      prev_wa = NODE_W'(clr_q);
      next_wa = NODE_W'(clr_q);
    end else if (cmd_i.phase1) begin
      case (act_q)
        ACT_UNLINK: begin
          prev_we = a_ok && n_ok;
          prev_wa = n_q;
          prev_wd = p_q;
          next_we = a_ok && p_ok;
          next_wa = p_q;
          next_wd = n_q;
        end
        ACT_INS_BEFORE: begin
          prev_we = ins_ok;
          prev_wa = b_q;
          prev_wd = p_q;
          next_we = ins_ok;
          next_wa = b_q;
          next_wd = a_q;
        end
        ACT_INS_AFTER: begin
          prev_we = ins_ok;
          prev_wa = b_q;
          prev_wd = a_q;
          next_we = ins_ok;
          next_wa = b_q;
          next_wd = n_q;
        end
        default: begin
          prev_we = 1'b0;
          next_we = 1'b0;
        end
      endcase
    end else if (cmd_i.phase2) begin
      case (act_q)
        ACT_UNLINK: begin
          prev_we = a_ok;
          next_we = a_ok;
        end
        ACT_INS_BEFORE: begin
          prev_we = ins_ok;
          prev_wd = b_q;
          next_we = ins_ok && p_ok;
          next_wa = p_q;
          next_wd = b_q;
        end
        ACT_INS_AFTER: begin
          prev_we = ins_ok && n_ok;
          prev_wa = n_q;
          prev_wd = b_q;
          next_we = ins_ok;
          next_wd = b_q;
        end
        default: begin
          prev_we = 1'b0;
          next_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[ADDR_W'(prev_wa)] <= prev_wd;
    if (cmd_i.accept) p_q <= prev_mem[ADDR_W'(node_a_i)];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[ADDR_W'(next_wa)] <= next_wd;
    if (cmd_i.accept) n_q <= next_mem[ADDR_W'(node_a_i)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= action_i;
      a_q   <= node_a_i;
      b_q   <= node_b_i;
    end
    if (cmd_i.load_out) begin
      prev_out_q <= a_ok ? p_q : '0;
      next_out_q <= a_ok ? n_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en && (clr_q != LAST)) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign status_o.is_query = (act_q == ACT_QUERY);
  assign status_o.clr_done = (clr_q == LAST);
  assign prev_node_o       = prev_out_q;
  assign next_node_o       = next_out_q;

endmodule

>>> src/linked_list_node_table.sv
// Doubly linked node table: prev/next links for nodes 1..1023, 0 meaning no link.
// An action's transfer cycle reads node_a's links from both link memories, then
// the states WR1 and WR2 write the changed entries, since each memory has one
// write port and an action rewrites up to two entries of the same memory. A
// query skips the writes and loads the result register in state WR1, or waits
// there while an earlier result is still held. After reset a clearing sweep
// zeroes both memories, and in_ready_o stays low until it ends.
module linked_list_node_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [llnt_pkg::ACT_W-1:0]  action_i,
  input  logic [llnt_pkg::NODE_W-1:0] node_a_i,
  input  logic [llnt_pkg::NODE_W-1:0] node_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [llnt_pkg::NODE_W-1:0] prev_node_o,
  output logic [llnt_pkg::NODE_W-1:0] next_node_o
);
  import llnt_pkg::*;

  cmd_t    cmd;
  status_t status;

  llnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  llnt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .prev_node_o (prev_node_o),
    .next_node_o (next_node_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!cmd.clr_en && !cmd.phase1 && !cmd.phase2 && !cmd.load_out))
    else $error("ready while table busy");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after transfer");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import llnt_pkg::*;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    node_t prev;
    node_t next;
  } link_pair_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    node_t            a;
    node_t            b;
    logic             typed;
    link_pair_t       want;
  } stim_row_t;

  localparam int NUM_DIR    = 27;
  localparam int NUM_RAND   = 1880;
  localparam int STALL_MAX  = 4000;
  localparam int BURST_LO   = 700;
  localparam int BURST_HI   = 1000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ACT_W-1:0] action_i;
  node_t            node_a_i;
  node_t            node_b_i;
  logic             out_valid_o;
  logic             out_ready_i;
  node_t            prev_node_o;
  node_t            next_node_o;

  node_t      prev_tbl [DEPTH];
  node_t      next_tbl [DEPTH];
  link_pair_t pending_links_q [$];

  bit no_idle;
  int mismatches;
  int items_sent;
  int queries_sent;
  int links_checked;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{ACT_QUERY,      10'd1,    10'd0,    1'b1, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd1023, 10'd1023, 1'b1, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd0,    10'd0,    1'b1, '{10'd0, 10'd0}},
    '{ACT_INS_AFTER,  10'd0,    10'd5,    1'b0, '{10'd0, 10'd0}},
    '{ACT_INS_BEFORE, 10'd5,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_INS_BEFORE, 10'd7,    10'd7,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd5,    10'd0,    1'b1, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd7,    10'd0,    1'b1, '{10'd0, 10'd0}},
    '{ACT_INS_AFTER,  10'd1,    10'd1023, 1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd1,    10'd0,    1'b1, '{10'd0, 10'd1023}},
    '{ACT_INS_BEFORE, 10'd1023, 10'd512,  1'b0, '{10'd0, 10'd0}},
    '{ACT_INS_AFTER,  10'd1023, 10'd2,    1'b0, '{10'd0, 10'd0}},
    '{ACT_INS_BEFORE, 10'd1,    10'd3,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd512,  10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd3,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_UNLINK,     10'd512,  10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd1,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd1023, 10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd512,  10'd0,    1'b1, '{10'd0, 10'd0}},
    '{ACT_UNLINK,     10'd3,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_UNLINK,     10'd2,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_UNLINK,     10'd700,  10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_INS_AFTER,  10'd2,    10'd1023, 1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd1,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd2,    10'd0,    1'b0, '{10'd0, 10'd0}},
    '{ACT_UNLINK,     10'd0,    10'd1023, 1'b0, '{10'd0, 10'd0}},
    '{ACT_QUERY,      10'd1023, 10'd682,  1'b0, '{10'd0, 10'd0}}
  };

  linked_list_node_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .prev_node_o (prev_node_o),
    .next_node_o (next_node_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit node_fits(input node_t n);
    return (n != '0) && (int'(n) <= MAX_NODES);
  endfunction

  function automatic bit update_links(input logic [ACT_W-1:0] act, input node_t a,
                                      input node_t b, output link_pair_t res);
    node_t p;
    node_t n;
    res = '0;
    if (act == ACT_QUERY) begin
      if (node_fits(a)) begin
        res.prev = prev_tbl[a];
        res.next = next_tbl[a];
      end
      return 1'b1;
    end
    if (!node_fits(a)) return 1'b0;
    if (act == ACT_UNLINK) begin
      p = prev_tbl[a];
      n = next_tbl[a];
      if (p != '0 && node_fits(p)) next_tbl[p] = n;
      if (n != '0 && node_fits(n)) prev_tbl[n] = p;
      prev_tbl[a] = '0;
      next_tbl[a] = '0;
      return 1'b0;
    end
    if (!node_fits(b) || b == a) return 1'b0;
    if (act == ACT_INS_BEFORE) begin
      p = prev_tbl[a];
      next_tbl[b] = a;
      prev_tbl[b] = p;
      if (p != '0 && node_fits(p)) next_tbl[p] = b;
      prev_tbl[a] = b;
    end else begin
      n = next_tbl[a];
      prev_tbl[b] = a;
      next_tbl[b] = n;
      next_tbl[a] = b;
      if (n != '0 && node_fits(n)) prev_tbl[n] = b;
    end
    return 1'b0;
  endfunction

  function automatic node_t pick_node();
    if ($urandom_range(31) == 0) return node_t'(MAX_NODES);
    if ($urandom_range(15) == 0) return node_t'($urandom_range(MAX_NODES, 1));
    return node_t'($urandom_range(24, 1));
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] error: %s", $realtime, what);
  endtask

  task automatic send_item(input logic [ACT_W-1:0] act, input node_t a, input node_t b,
                           input logic typed, input link_pair_t want);
    link_pair_t pred;
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    node_a_i   <= a;
    node_b_i   <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (update_links(act, a, b, pred)) begin
      queries_sent++;
      pending_links_q.push_back(typed ? want : pred);
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_links_q.size() == 0) begin
        note_mismatch($sformatf("result prev=%0d next=%0d with none pending",
                                prev_node_o, next_node_o));
      end else begin
        links_checked++;
        if (prev_node_o !== pending_links_q[0].prev ||
            next_node_o !== pending_links_q[0].next) begin
          note_mismatch($sformatf("expected prev=%0d next=%0d, got prev=%0d next=%0d",
                                  pending_links_q[0].prev, pending_links_q[0].next,
                                  prev_node_o, next_node_o));
        end
        void'(pending_links_q.pop_front());
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall = 0;
      else stall++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_MAX);
    $display("linked_list_node_table: mismatch");
    $finish;
  end

  initial begin
    int         i;
    int         r;
    int         tries;
    logic [ACT_W-1:0] act;
    node_t      a;
    node_t      b;
    link_pair_t none;
    none = '0;
    no_idle = 1'b0;
    mismatches = 0;
    items_sent = 0;
    queries_sent = 0;
    links_checked = 0;
    for (i = 0; i < DEPTH; i++) begin
      prev_tbl[i] = '0;
      next_tbl[i] = '0;
    end
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= ACT_UNLINK;
    node_a_i   <= '0;
    node_b_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_DIR; i++) begin
      send_item(dir_rows[i].act, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
                dir_rows[i].want);
    end

    for (i = 0; i < NUM_RAND; i++) begin
      no_idle = (i >= BURST_LO) && (i < BURST_HI);
      r = $urandom_range(99);
      b = node_t'($urandom);
      if (r < 30) begin
        act = ACT_QUERY;
        a = pick_node();
      end else if (r < 50) begin
        act = ACT_UNLINK;
        a = pick_node();
      end else if (r < 88) begin
        act = ($urandom_range(1) == 0) ? ACT_INS_BEFORE : ACT_INS_AFTER;
        a = pick_node();
        tries = 0;
        do begin
          b = pick_node();
          tries++;
        end while (tries < 8 && (b == a || prev_tbl[b] != '0 || next_tbl[b] != '0));
      end else begin
        act = ACT_W'($urandom_range(3));
        a = node_t'($urandom);
        if ($urandom_range(3) == 0) a = '0;
        if ($urandom_range(3) == 0) b = a;
      end
      send_item(act, a, b, 1'b0, none);
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_links_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d actions (%0d queries), checked %0d query results",
             items_sent, queries_sent, links_checked);
    $display("covered empty tables, list splicing at head, middle and tail, and bad nodes");
    if (mismatches == 0) begin
      $display("linked_list_node_table: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("linked_list_node_table: mismatch");
    end
    $finish;
  end

endmodule
